FILE: rtl/core/ipf_pkg.sv
`default_nettype none

package ipf_pkg;

    // Packet and half header words
    localparam logic [15:0] WORD_PKT_MAGIC = 16'hEFFE;
    localparam logic [15:0] WORD_PKT_EP    = 16'h0106;
    localparam logic [15:0] WORD_SYNC_A    = 16'h7F7F;
    localparam logic [15:0] WORD_SYNC_B    = 16'h7F00;
    localparam logic [15:0] WORD_CTRL_A    = 16'h0000;
    localparam logic [15:0] WORD_CTRL_B    = 16'h001D;
    localparam logic [15:0] WORD_ZERO      = 16'h0000;

    localparam int MAX_RECEIVERS = 8;
    localparam int RX_IDX_W      = $clog2(MAX_RECEIVERS);
    localparam int RX_W          = 4;

    // Word positions inside each section
    localparam logic [5:0] POS_HDR_LAST  = 6'd3;
    localparam logic [5:0] POS_SYNC_LAST = 6'd3;
    localparam logic [5:0] POS_SAMP_LAST = 6'd2;

    typedef struct packed {
        logic        action;
        logic [47:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [15:0] word;
        logic        end_of_packet;
        logic        end_of_run;
    } out_item_t;

    // One classified sample slot, ready for the word sequencer
    typedef struct packed {
        logic [47:0] sample;
        logic [31:0] seq;
        logic        hdr;
        logic        sync;
        logic [5:0]  zeros;
        logic        eop;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_SYNC,
        ST_SAMP,
        ST_ZERO
    } back_state_t;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_STOP   = 1'b1;

    // Map a raw receivers value to a 0-based index, clamped to 1..MAX_RECEIVERS
    function automatic logic [RX_IDX_W-1:0] rx_index(input logic [RX_W-1:0] r);
        logic [RX_IDX_W-1:0] idx;
        begin
            if (r == '0) begin
                idx = '0;
            end else if (r > RX_W'(MAX_RECEIVERS)) begin
                idx = RX_IDX_W'(MAX_RECEIVERS - 1);
            end else begin
                idx = RX_IDX_W'(r - RX_W'(1));
            end
            return idx;
        end
    endfunction

    // Slots per half: 504 / (8 + 6*(r-1))
    function automatic logic [5:0] slots_of(input logic [RX_IDX_W-1:0] idx);
        logic [5:0] s;
        begin
            case (idx)
                3'd0:    s = 6'd63;
                3'd1:    s = 6'd36;
                3'd2:    s = 6'd25;
                3'd3:    s = 6'd19;
                3'd4:    s = 6'd15;
                3'd5:    s = 6'd13;
                3'd6:    s = 6'd11;
                3'd7:    s = 6'd10;
                default: s = 6'd63;
            endcase
            return s;
        end
    endfunction

    // Zero words after the three sample words: 3r - 2
    function automatic logic [4:0] pad_of(input logic [RX_IDX_W-1:0] idx);
        logic [4:0] p;
        begin
            case (idx)
                3'd0:    p = 5'd1;
                3'd1:    p = 5'd4;
                3'd2:    p = 5'd7;
                3'd3:    p = 5'd10;
                3'd4:    p = 5'd13;
                3'd5:    p = 5'd16;
                3'd6:    p = 5'd19;
                3'd7:    p = 5'd22;
                default: p = 5'd1;
            endcase
            return p;
        end
    endfunction

    // Zero words filling the end of a half
    function automatic logic [3:0] fill_of(input logic [RX_IDX_W-1:0] idx);
        logic [3:0] f;
        begin
            case (idx)
                3'd0:    f = 4'd0;
                3'd1:    f = 4'd0;
                3'd2:    f = 4'd2;
                3'd3:    f = 4'd5;
                3'd4:    f = 4'd12;
                3'd5:    f = 4'd5;
                3'd6:    f = 4'd10;
                3'd7:    f = 4'd2;
                default: f = 4'd0;
            endcase
            return f;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ipf_front.sv
`default_nettype none

module ipf_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ipf_pkg::in_item_t   in_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [3:0]          cfg_data,
    input  wire ipf_pkg::q_status_t  q_stat,
    output logic                     push,
    output ipf_pkg::job_t            push_job
);
    import ipf_pkg::*;

    logic [RX_W-1:0]     rx_reg;
    logic [RX_IDX_W-1:0] prx_reg, prx_next;
    logic [31:0]         seq_reg, seq_next;
    logic                half_reg, half_next;
    logic [5:0]          slot_reg, slot_next;

    logic                accept;
    logic                start;
    logic [RX_IDX_W-1:0] idx;
    logic [5:0]          slots;
    logic                last_slot;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_stat.full;
    assign accept    = in_valid && !in_stall;

    // Classify the slot position and pick the receiver count for this packet
    assign start     = !half_reg && (slot_reg == 6'd0);
    assign idx       = start ? rx_index(rx_reg) : prx_reg;
    assign slots     = slots_of(idx);
    assign last_slot = ({1'b0, slot_reg} + 7'd1) >= {1'b0, slots};

    assign push = accept && (in_data.action == ACT_SAMPLE);

    always_comb
    begin
        push_job.sample = in_data.sample;
        push_job.seq    = seq_reg;
        push_job.hdr    = start;
        push_job.sync   = (slot_reg == 6'd0);
        push_job.zeros  = 6'(pad_of(idx)) + (last_slot ? {2'b00, fill_of(idx)} : 6'd0);
        push_job.eop    = last_slot && half_reg;
    end

    // Advance the packet position and sequence number; a stop clears the sequence number
    always_comb
    begin
        seq_next  = seq_reg;
        half_next = half_reg;
        slot_next = slot_reg;
        prx_next  = prx_reg;
        if (accept && (in_data.action == ACT_STOP)) begin
            seq_next = '0;
        end else if (push) begin
            if (start) begin
                seq_next = seq_reg + 32'd1;
                prx_next = idx;
            end
            if (last_slot) begin
                half_next = !half_reg;
                slot_next = '0;
            end else begin
                slot_next = slot_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rx_reg   <= RX_W'(1);
            prx_reg  <= '0;
            seq_reg  <= '0;
            half_reg <= 1'b0;
            slot_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                rx_reg <= cfg_data;
            end
            prx_reg  <= prx_next;
            seq_reg  <= seq_next;
            half_reg <= half_next;
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ipf_queue.sv
`default_nettype none

module ipf_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ipf_pkg::job_t      push_job,
    input  wire logic               pop,
    output ipf_pkg::job_t           head,
    output ipf_pkg::q_status_t      q_stat
);
    import ipf_pkg::*;

    job_t       slot_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign head         = slot_mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Hold entries; no reset needed on the payload
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ipf_back.sv
`default_nettype none

module ipf_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ipf_pkg::job_t       head,
    input  wire ipf_pkg::q_status_t  q_stat,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ipf_pkg::out_item_t       out_data
);
    import ipf_pkg::*;

    back_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    job_t        job_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic        adv;
    logic        last_word;
    logic [15:0] word;
    back_state_t first_state;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign first_state = head.hdr ? ST_HDR : (head.sync ? ST_SYNC : ST_SAMP);

    // Output decode: current word, end of run, dequeue
    always_comb
    begin
        adv       = 1'b0;
        last_word = 1'b0;
        word      = WORD_ZERO;
        pop       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop = !q_stat.empty;
            end
            ST_HDR:
            begin
                adv = !out_valid_reg || !out_stall;
                case (cnt_reg[1:0])
                    2'd0:    word = WORD_PKT_MAGIC;
                    2'd1:    word = WORD_PKT_EP;
                    2'd2:    word = job_reg.seq[31:16];
                    default: word = job_reg.seq[15:0];
                endcase
            end
            ST_SYNC:
            begin
                adv = !out_valid_reg || !out_stall;
                case (cnt_reg[1:0])
                    2'd0:    word = WORD_SYNC_A;
                    2'd1:    word = WORD_SYNC_B;
                    2'd2:    word = WORD_CTRL_A;
                    default: word = WORD_CTRL_B;
                endcase
            end
            ST_SAMP:
            begin
                adv = !out_valid_reg || !out_stall;
                case (cnt_reg[1:0])
                    2'd0:    word = job_reg.sample[47:32];
                    2'd1:    word = job_reg.sample[31:16];
                    default: word = job_reg.sample[15:0];
                endcase
            end
            ST_ZERO:
            begin
                adv       = !out_valid_reg || !out_stall;
                word      = WORD_ZERO;
                last_word = (cnt_reg == (job_reg.zeros - 6'd1));
                pop       = adv && last_word && !q_stat.empty;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Next state: walk header, sync, sample and zero sections
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty) begin
                    state_next = first_state;
                    cnt_next   = '0;
                end
            end
            ST_HDR:
            begin
                if (adv) begin
                    if (cnt_reg == POS_HDR_LAST) begin
                        state_next = ST_SYNC;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            ST_SYNC:
            begin
                if (adv) begin
                    if (cnt_reg == POS_SYNC_LAST) begin
                        state_next = ST_SAMP;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            ST_SAMP:
            begin
                if (adv) begin
                    if (cnt_reg == POS_SAMP_LAST) begin
                        state_next = ST_ZERO;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            ST_ZERO:
            begin
                if (adv) begin
                    if (last_word) begin
                        cnt_next   = '0;
                        state_next = q_stat.empty ? ST_IDLE : first_state;
                    end else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Load the next job as it leaves the queue; register the output word on advance
    always_ff @(posedge clk)
    begin
        if (pop) begin
            job_reg <= head;
        end
        if (adv) begin
            out_data_reg.word          <= word;
            out_data_reg.end_of_run    <= last_word;
            out_data_reg.end_of_packet <= last_word && job_reg.eop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("dequeue from empty queue");

    a_zero_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ZERO) |-> (cnt_reg < job_reg.zeros))
        else $error("zero run counter beyond run length");

    a_hdr_has_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HDR) |-> job_reg.sync)
        else $error("packet header without half header");

    a_valid_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != ST_IDLE))
        else $error("output word raised while sequencer idle");

    a_eop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.end_of_packet) |-> out_data_reg.end_of_run)
        else $error("end of packet not at end of run");

endmodule

`default_nettype wire

FILE: rtl/core/iq_sample_packet_framer_unit.sv
// IQ sample packet framer.
// Input channel (in_valid / in_stall / in_data): one item per transfer. A
// sample item fills one slot of a 1032-byte packet; a stop item clears the
// sequence number and produces no words. in_stall is high only while the
// two-entry slot queue between classifier and word sequencer is full.
// Output channel (out_valid / out_stall / out_data): one big-endian 16-bit
// word per transfer; end_of_run marks an item's last word, end_of_packet the
// packet's last word.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): receivers, always
// ready; takes effect at the next packet start.
// Path: slot queue, then the sequencer's job register, then the output word register.
// Throughput: the word sequencer emits one word per cycle while out_stall is
// low; an item is 3*receivers+1 words, plus 4 at a packet start, 4 at a half
// start and 0..12 fill words at a half end (25 words at eight receivers).
// Reset: sequence number zero, packet start, receivers 1, no words pending.
// When the receiver stalls the output word holds, the sequencer waits and
// the queue absorbs up to two further items before in_stall rises.
`default_nettype none

module iq_sample_packet_framer_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ipf_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ipf_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_data
);
    import ipf_pkg::*;

    q_status_t q_stat;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head;

    ipf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    ipf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    ipf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import ipf_pkg::*;

    localparam int HALF_PAYLOAD    = 504;
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_CYCLES     = 300;
    localparam int PRINT_LIMIT     = 100;
    localparam int PHASES          = 11;
    localparam int ITEMS_PER_PHASE = 28;

    // Directed rows either write the receivers register or send one item
    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    localparam logic [5:0] UNTYPED = 6'd63;

    typedef struct packed {
        row_kind_t         kind;
        logic [3:0]        rx_value;
        in_item_t          item;
        logic [5:0]        n_typed;
        logic [0:32][15:0] words;
    } dir_row_t;

    localparam int DIR_ROWS = 25;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // above the maximum: first packet runs at eight receivers, stride 50
        '{ROW_CFG, 4'd9, '{ACT_SAMPLE, 48'h0}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'hFFFF_FFFF_FFFF}, 6'd33,
          {16'hEFFE, 16'h0106, 16'h0000, 16'h0000, 16'h7F7F, 16'h7F00, 16'h0000,
           16'h001D, 48'hFFFF_FFFF_FFFF, 352'h0}},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h0}, 6'd25, '0},
        '{ROW_ITEM, 4'd0, '{ACT_STOP, 48'hFFFF_FFFF_FFFF}, 6'd0, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h8000_0000_0001}, 6'd25,
          {48'h8000_0000_0001, 480'h0}},
        // mid-packet write: stride stays at 50 until the next packet
        '{ROW_CFG, 4'd3, '{ACT_SAMPLE, 48'h0}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h5555_5555_5555}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'hAAAA_AAAA_AAAA}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h0123_4567_89AB}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'hFEDC_BA98_7654}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'hFFFF_0000_0000}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h0000_FFFF_0000}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h0000_0000_FFFF}, UNTYPED, '0},
        // second half of the packet, last slot carries end of packet
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h8000_0000_0000}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h0000_0000_0001}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h7FFF_FFFF_FFFF}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h1111_2222_3333}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h4444_5555_6666}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h7777_8888_9999}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'hAAAA_BBBB_CCCC}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'hDDDD_EEEE_FFFF}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h0F0F_F0F0_0F0F}, UNTYPED, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'hF0F0_0F0F_F0F0}, UNTYPED, '0},
        // stop clears the sequence number: the next packet header carries zero
        '{ROW_ITEM, 4'd0, '{ACT_STOP, 48'h0}, 6'd0, '0},
        '{ROW_ITEM, 4'd0, '{ACT_SAMPLE, 48'h1234_5678_9ABC}, 6'd18,
          {16'hEFFE, 16'h0106, 16'h0000, 16'h0000, 16'h7F7F, 16'h7F00, 16'h0000,
           16'h001D, 48'h1234_5678_9ABC, 352'h0}}
    };

    // Receivers setting and idling per random phase
    localparam logic [3:0] PHASE_RX [PHASES] = '{
        4'd8, 4'd5, 4'd15, 4'd6, 4'd7, 4'd4, 4'd2, 4'd3, 4'd1, 4'd0, 4'd9
    };
    localparam int SEND_GAP [4]   = '{0, 63, 0, 25};
    localparam int RECV_STALL [4] = '{0, 0, 63, 25};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;

    // Framer state as the testbench sees it
    logic [3:0]  rx_setting = 4'd1;
    logic [31:0] seq_num    = 32'd0;
    logic        half_sel   = 1'b0;
    logic [5:0]  slot_pos   = 6'd0;
    int          pkt_rx     = 1;

    out_item_t frame_words [$];

    int mismatch_count = 0;
    int send_gap_pct   = 0;
    int stall_pct      = 0;
    int hold_asked     = 0;
    int hold_done      = 0;

    iq_sample_packet_framer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("%0t ERROR: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic void add_word(ref out_item_t q[$], input logic [15:0] value);
        out_item_t w;
        w      = '0;
        w.word = value;
        q.push_back(w);
    endfunction

    // Work out the words one item produces and advance the framing state
    function automatic void frame_item(input in_item_t it, ref out_item_t q[$]);
        int stride;
        int slots;
        int i;
        q = {};
        if (it.action == ACT_STOP)
        begin
            seq_num = '0;
            return;
        end
        // latch the receivers count at the packet start, clamped to 1..max
        if (!half_sel && slot_pos == 6'd0)
        begin
            if (rx_setting == 4'd0)
            begin
                pkt_rx = 1;
            end
            else if (rx_setting > MAX_RECEIVERS)
            begin
                pkt_rx = MAX_RECEIVERS;
            end
            else
            begin
                pkt_rx = int'(rx_setting);
            end
            add_word(q, 16'hEFFE);
            add_word(q, 16'h0106);
            add_word(q, seq_num[31:16]);
            add_word(q, seq_num[15:0]);
            seq_num = seq_num + 32'd1;
        end
        stride = 8 + 6 * (pkt_rx - 1);
        slots  = HALF_PAYLOAD / stride;
        // sync and control bytes open each half
        if (slot_pos == 6'd0)
        begin
            add_word(q, 16'h7F7F);
            add_word(q, 16'h7F00);
            add_word(q, 16'h0000);
            add_word(q, 16'h001D);
        end
        add_word(q, it.sample[47:32]);
        add_word(q, it.sample[31:16]);
        add_word(q, it.sample[15:0]);
        for (i = 6; i < stride; i += 2)
        begin
            add_word(q, 16'h0000);
        end
        // last slot of a half: zero fill, then flip halves
        if (int'(slot_pos) + 1 >= slots)
        begin
            for (i = slots * stride; i < HALF_PAYLOAD; i += 2)
            begin
                add_word(q, 16'h0000);
            end
            if (half_sel)
            begin
                q[q.size() - 1].end_of_packet = 1'b1;
            end
            half_sel = ~half_sel;
            slot_pos = 6'd0;
        end
        else
        begin
            slot_pos = slot_pos + 6'd1;
        end
        q[q.size() - 1].end_of_run = 1'b1;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        pick      = $urandom_range(99);
        it.action = (pick < 6) ? ACT_STOP : ACT_SAMPLE;
        if (pick >= 6 && pick < 10)
        begin
            it.sample = '1;
        end
        else if (pick >= 10 && pick < 14)
        begin
            it.sample = '0;
        end
        else
        begin
            it.sample = {16'($urandom()), 32'($urandom())};
        end
        return it;
    endfunction

    // Offer one item, hold it until the transfer, then queue its words
    task automatic send_item(input in_item_t it, input logic [5:0] n_typed,
                             input logic [0:32][15:0] typed);
        out_item_t predicted [$];
        out_item_t w;
        int        k;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        frame_item(it, predicted);
        if (n_typed == UNTYPED)
        begin
            foreach (predicted[j])
            begin
                frame_words.push_back(predicted[j]);
            end
        end
        else
        begin
            for (k = 0; k < int'(n_typed); k++)
            begin
                w            = '0;
                w.word       = typed[k];
                w.end_of_run = (k == int'(n_typed) - 1);
                frame_words.push_back(w);
            end
        end
    endtask

    // Write receivers once the framer has gone quiet
    task automatic write_receivers(input logic [3:0] value);
        in_valid <= 1'b0;
        while (frame_words.size() != 0)
        begin
            @(posedge clk);
        end
        // let the output side settle before the write
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        rx_setting = value;
    endtask

    // Output side: random stalls, plus long hold-offs when asked for
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_done)
            begin
                hold_done++;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each output transfer with the oldest expected word
    always @(posedge clk)
    begin : word_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h", out_data.word));
            end
            else
            begin
                want = frame_words.pop_front();
                if (out_data.word !== want.word)
                begin
                    report_mismatch($sformatf("word %h, expected %h",
                                              out_data.word, want.word));
                end
                if (out_data.end_of_packet !== want.end_of_packet)
                begin
                    report_mismatch($sformatf("end_of_packet %b, expected %b",
                                              out_data.end_of_packet, want.end_of_packet));
                end
                if (out_data.end_of_run !== want.end_of_run)
                begin
                    report_mismatch($sformatf("end_of_run %b, expected %b",
                                              out_data.end_of_run, want.end_of_run));
                end
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int p;
        int n;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (DIR_TABLE[r].kind == ROW_CFG)
            begin
                write_receivers(DIR_TABLE[r].rx_value);
            end
            else
            begin
                send_item(DIR_TABLE[r].item, DIR_TABLE[r].n_typed, DIR_TABLE[r].words);
            end
        end

        // random items, one receivers setting and idling pattern per phase
        for (p = 0; p < PHASES; p++)
        begin
            write_receivers(PHASE_RX[p]);
            send_gap_pct = SEND_GAP[p % 4];
            stall_pct    = RECV_STALL[p % 4];
            if (p == 2 || p == 6)
            begin
                hold_asked++;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_item(random_item(), UNTYPED, '0);
            end
        end

        // drain, then allow stray words to show up
        in_valid <= 1'b0;
        while (frame_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: iq_sample_packet_framer_unit.f
rtl/core/ipf_pkg.sv
rtl/core/ipf_front.sv
rtl/core/ipf_queue.sv
rtl/core/ipf_back.sv
rtl/core/iq_sample_packet_framer_unit.sv
dv/testbench.sv
